[src/ers_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes for the elevator request scheduler
// no dependencies
package ers_pkg;

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_ARRIVE  = 2'd1;
    localparam logic [1:0] MODE_MOVE    = 2'd2;

    localparam logic [1:0] DIR_STAY = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    typedef struct packed {
        logic load;
        logic exec;
        logic goal_step;
        logic disp_init;
        logic disp_step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_goal;
        logic need_disp;
        logic scan_stop;
    } t_dp_sts;

endpackage

[src/ers_ctrl.sv]
`timescale 1ns / 1ps
// sequencing controller for the elevator request scheduler
// depends on ers_pkg
module ers_ctrl
    import ers_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_GOAL   = 6'b000100,
        S_DSTART = 6'b001000,
        S_DISP   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_goal) begin
                    n_state = S_GOAL;
                end else if (i_sts.need_disp) begin
                    n_state = S_DSTART;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_GOAL: begin
                o_cmd.goal_step = 1'b1;
                if (i_sts.scan_stop) begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                o_cmd.disp_init = 1'b1;
                n_state         = S_DISP;
            end
            S_DISP: begin
                o_cmd.disp_step = 1'b1;
                if (i_sts.scan_stop) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.publish = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

[src/ers_dpath.sv]
`timescale 1ns / 1ps
// scheduler datapath: pending bitmap, cabin, goal, direction, scan index
// depends on ers_pkg, driven by ers_ctrl
module ers_dpath
    import ers_pkg::*;
#(
    parameter int FLOOR_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [1:0]        i_mode,
    input  logic [4:0]        i_floor,
    input  logic signed [1:0] i_move_dir,
    output logic              o_result_valid,
    output logic              o_dispatch_valid,
    output logic [4:0]        o_dispatch_floor,
    output logic signed [1:0] o_dispatch_dir,
    output logic [4:0]        o_cabin_floor,
    output logic [4:0]        o_goal_floor,
    output logic              o_is_busy
);

    localparam int IW = $clog2(FLOOR_COUNT + 1);
    localparam int PW = $clog2(FLOOR_COUNT);
    localparam logic [IW-1:0] FC  = IW'(FLOOR_COUNT);
    localparam logic [IW-1:0] ONE = IW'(1);

    logic [1:0]             r_mode;
    logic [4:0]             r_floor;
    logic [1:0]             r_move_dir;
    logic [FLOOR_COUNT-1:0] r_pending;
    logic [IW-1:0]          r_cabin;
    logic [IW-1:0]          r_goal;
    logic                   r_busy;
    logic [1:0]             r_dir;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          r_bound;
    logic                   r_up;
    logic                   r_disp_valid;
    logic [IW-1:0]          r_disp_floor;
    logic [1:0]             r_disp_dir;
    logic                   r_out_valid;
    logic                   r_o_disp_valid;
    logic [4:0]             r_o_disp_floor;
    logic [1:0]             r_o_disp_dir;
    logic [4:0]             r_o_cabin;
    logic [4:0]             r_o_goal;
    logic                   r_o_busy;

    logic          f_ok;
    logic [IW-1:0] f_n;
    logic [IW-1:0] f_m1;
    logic [IW-1:0] idx_m1;
    logic          is_req;
    logic          is_arr;
    logic          is_move;
    logic          hit;
    logic          at_bound;

    assign f_ok     = (r_floor != 5'd0) && (int'(r_floor) <= FLOOR_COUNT);
    assign f_n      = IW'(r_floor);
    assign f_m1     = f_n - ONE;
    assign idx_m1   = r_idx - ONE;
    assign is_req   = (r_mode == MODE_REQUEST) && f_ok;
    assign is_arr   = (r_mode == MODE_ARRIVE) && f_ok;
    assign is_move  = (r_mode == MODE_MOVE) && r_busy;
    assign hit      = r_pending[idx_m1[PW-1:0]];
    assign at_bound = (r_idx == r_bound);

    assign o_sts.need_goal = is_arr && (f_n == r_goal);
    assign o_sts.need_disp = (is_req && !r_busy) || is_arr;
    assign o_sts.scan_stop = hit || at_bound;

    // captured item, scan bookkeeping and published output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_floor    <= i_floor;
            r_move_dir <= i_move_dir;
        end
        if (i_cmd.exec) begin
            r_idx   <= (r_dir == DIR_UP) ? FC : ONE;
            r_bound <= (r_dir == DIR_UP) ? ONE : FC;
            r_up    <= (r_dir != DIR_UP);
        end else if (i_cmd.disp_init) begin
            r_idx   <= r_cabin;
            r_bound <= (r_goal > r_cabin) ? FC : ONE;
            r_up    <= (r_goal > r_cabin);
        end else if ((i_cmd.goal_step || i_cmd.disp_step) && !hit && !at_bound) begin
            r_idx <= r_up ? (r_idx + ONE) : (r_idx - ONE);
        end
        if (i_cmd.publish) begin
            r_o_disp_valid <= r_disp_valid;
            r_o_disp_floor <= 5'(r_disp_floor);
            r_o_disp_dir   <= r_disp_dir;
            r_o_cabin      <= 5'(r_cabin);
            r_o_goal       <= 5'(r_goal);
            r_o_busy       <= r_busy;
        end
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_cabin      <= ONE;
            r_goal       <= '0;
            r_busy       <= 1'b0;
            r_dir        <= DIR_STAY;
            r_disp_valid <= 1'b0;
            r_disp_floor <= '0;
            r_disp_dir   <= DIR_STAY;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.publish;
            if (i_cmd.exec) begin
                r_disp_valid <= 1'b0;
                r_disp_floor <= '0;
                r_disp_dir   <= DIR_STAY;
                if (is_req) begin
                    if (r_goal != f_n) begin
                        r_pending[f_m1[PW-1:0]] <= 1'b1;
                    end
                    if (r_goal == '0) begin
                        r_goal <= f_n;
                    end else if (r_dir != DIR_DOWN && f_n > r_goal) begin
                        r_goal <= f_n;
                    end else if (r_dir != DIR_UP && f_n < r_goal) begin
                        r_goal <= f_n;
                    end
                end else if (is_arr) begin
                    r_busy  <= 1'b0;
                    r_cabin <= f_n;
                    if (f_n == r_goal) begin
                        r_goal <= '0;
                    end
                end else if (is_move) begin
                    if (r_move_dir == DIR_UP && r_cabin < FC) begin
                        r_cabin <= r_cabin + ONE;
                    end else if (r_move_dir == DIR_DOWN && r_cabin > ONE) begin
                        r_cabin <= r_cabin - ONE;
                    end
                end
            end
            if (i_cmd.goal_step && hit) begin
                r_goal <= r_idx;
            end
            if (i_cmd.disp_step && hit) begin
                r_pending[idx_m1[PW-1:0]] <= 1'b0;
                r_busy       <= 1'b1;
                r_disp_valid <= 1'b1;
                r_disp_floor <= r_idx;
                if (r_idx == r_cabin) begin
                    r_dir      <= DIR_STAY;
                    r_disp_dir <= DIR_STAY;
                end else begin
                    r_dir      <= r_up ? DIR_UP : DIR_DOWN;
                    r_disp_dir <= r_up ? DIR_UP : DIR_DOWN;
                end
            end
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_dispatch_valid = r_o_disp_valid;
    assign o_dispatch_floor = r_o_disp_floor;
    assign o_dispatch_dir   = r_o_disp_dir;
    assign o_cabin_floor    = r_o_cabin;
    assign o_goal_floor     = r_o_goal;
    assign o_is_busy        = r_o_busy;

endmodule

[src/elevator_request_scheduler.sv]
`timescale 1ns / 1ps
// elevator request scheduler top: controller plus datapath
// depends on ers_pkg, ers_ctrl, ers_dpath
// o_result_valid pulses with the published outputs, after S_EXEC, the optional goal and dispatch scans, and S_DONE
// the far-goal scan and the dispatch scan each visit one floor per cycle
// a new item is taken only in S_IDLE, after the last one is published; the receiver cannot stall
// synchronous reset: no pending floors, cabin at floor 1, no goal, ready, static
module elevator_request_scheduler
    import ers_pkg::*;
#(
    parameter int FLOOR_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_mode,
    input  logic [4:0]        i_floor,
    input  logic signed [1:0] i_move_dir,
    output logic              o_result_valid,
    output logic              o_dispatch_valid,
    output logic [4:0]        o_dispatch_floor,
    output logic signed [1:0] o_dispatch_dir,
    output logic [4:0]        o_cabin_floor,
    output logic [4:0]        o_goal_floor,
    output logic              o_is_busy
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ers_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ers_dpath #(
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_mode),
        .i_floor          (i_floor),
        .i_move_dir       (i_move_dir),
        .o_result_valid   (o_result_valid),
        .o_dispatch_valid (o_dispatch_valid),
        .o_dispatch_floor (o_dispatch_floor),
        .o_dispatch_dir   (o_dispatch_dir),
        .o_cabin_floor    (o_cabin_floor),
        .o_goal_floor     (o_goal_floor),
        .o_is_busy        (o_is_busy)
    );

endmodule

[tb/sv/tb_elevator_request_scheduler.sv]
`timescale 1ns / 1ps
// self-checking testbench for elevator_request_scheduler: directed and random panel events
// depends on ers_pkg and the elevator_request_scheduler rtl
module tb_elevator_request_scheduler;
    import ers_pkg::*;

    localparam int FLOORS = 16;
    localparam int RANDOM_EVENTS = 2000;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] floor;
        logic [1:0] mdir;
    } panel_event_t;

    typedef struct packed {
        logic       dv;
        logic [4:0] df;
        logic [1:0] dd;
        logic [4:0] cf;
        logic [4:0] gf;
        logic       ib;
    } panel_status_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_mode = MODE_REQUEST;
    logic [4:0]        i_floor = 5'd1;
    logic signed [1:0] i_move_dir = DIR_STAY;
    logic              o_result_valid;
    logic              o_dispatch_valid;
    logic [4:0]        o_dispatch_floor;
    logic signed [1:0] o_dispatch_dir;
    logic [4:0]        o_cabin_floor;
    logic [4:0]        o_goal_floor;
    logic              o_is_busy;

    panel_event_t  panel_events_q[$];
    panel_status_t predicted_status_q[$];

    // scheduler state as predicted from accepted transfers
    logic [FLOORS:1] pend_map = '0;
    int              cab_pos = 1;
    int              goal_pos = 0;
    logic            moving = 1'b0;
    logic [1:0]      travel = DIR_STAY;

    bit took = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    int cycles = 0;
    int errors = 0;
    int transfers = 0;
    int results = 0;
    int dispatches = 0;
    int mode_seen[4] = '{0, 0, 0, 0};

    elevator_request_scheduler #(
        .FLOOR_COUNT(FLOORS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_floor         (i_floor),
        .i_move_dir      (i_move_dir),
        .o_result_valid  (o_result_valid),
        .o_dispatch_valid(o_dispatch_valid),
        .o_dispatch_floor(o_dispatch_floor),
        .o_dispatch_dir  (o_dispatch_dir),
        .o_cabin_floor   (o_cabin_floor),
        .o_goal_floor    (o_goal_floor),
        .o_is_busy       (o_is_busy)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void add_event(logic [1:0] mode, logic [4:0] floor, logic [1:0] mdir);
        panel_event_t ev;
        ev.mode = mode;
        ev.floor = floor;
        ev.mdir = mdir;
        panel_events_q.push_back(ev);
    endfunction

    // cabin floor first, then nearest pending floor toward the goal
    function automatic void seek_floor(inout panel_status_t st);
        int f;
        int pick;
        logic [1:0] d;
        pick = 0;
        d = DIR_STAY;
        if (pend_map[cab_pos]) begin
            pick = cab_pos;
        end else if (goal_pos > cab_pos) begin
            for (f = cab_pos; f <= FLOORS; f++) begin
                if (pend_map[f]) begin
                    pick = f;
                    d = DIR_UP;
                    break;
                end
            end
        end else begin
            for (f = cab_pos; f >= 1; f--) begin
                if (pend_map[f]) begin
                    pick = f;
                    d = DIR_DOWN;
                    break;
                end
            end
        end
        if (pick != 0) begin
            pend_map[pick] = 1'b0;
            moving = 1'b1;
            travel = d;
            st.dv = 1'b1;
            st.df = 5'(pick);
            st.dd = d;
        end
    endfunction

    function automatic panel_status_t schedule_event(panel_event_t ev);
        panel_status_t st;
        bit in_range;
        int f;
        st = '0;
        in_range = ev.floor >= 1 && ev.floor <= FLOORS;
        if (ev.mode == MODE_REQUEST && in_range) begin
            if (goal_pos != ev.floor)
                pend_map[ev.floor] = 1'b1;
            if (goal_pos == 0)
                goal_pos = ev.floor;
            else if (travel != DIR_DOWN && ev.floor > goal_pos)
                goal_pos = ev.floor;
            else if (travel != DIR_UP && ev.floor < goal_pos)
                goal_pos = ev.floor;
            if (!moving)
                seek_floor(st);
        end else if (ev.mode == MODE_ARRIVE && in_range) begin
            moving = 1'b0;
            cab_pos = ev.floor;
            if (cab_pos == goal_pos) begin
                // goal reached: new goal at the far end of the pending set
                goal_pos = 0;
                if (travel == DIR_UP) begin
                    for (f = FLOORS; f >= 1; f--) begin
                        if (pend_map[f]) begin
                            goal_pos = f;
                            break;
                        end
                    end
                end else begin
                    for (f = 1; f <= FLOORS; f++) begin
                        if (pend_map[f]) begin
                            goal_pos = f;
                            break;
                        end
                    end
                end
            end
            seek_floor(st);
        end else if (ev.mode == MODE_MOVE && moving) begin
            if (ev.mdir == DIR_UP && cab_pos < FLOORS)
                cab_pos++;
            else if (ev.mdir == DIR_DOWN && cab_pos > 1)
                cab_pos--;
        end
        st.cf = 5'(cab_pos);
        st.gf = 5'(goal_pos);
        st.ib = moving;
        return st;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // driver: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin
        bit hold;
        hold = start && !took;
        if (took) begin
            void'(panel_events_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 20);
                gap_left = $urandom_range(1) ? 0 : $urandom_range(1, 8);
            end
        end
        if (!i_rst_n || hold) begin
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (panel_events_q.size() > 0) begin
            start <= 1'b1;
            i_mode <= panel_events_q[0].mode;
            i_floor <= panel_events_q[0].floor;
            i_move_dir <= panel_events_q[0].mdir;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: check results, predict on each accepted transfer
    always @(posedge i_clk) begin
        panel_status_t got;
        panel_status_t want;
        panel_event_t ev;
        took = i_rst_n && start && !busy;
        if (i_rst_n && o_result_valid) begin
            got = '{o_dispatch_valid, o_dispatch_floor, o_dispatch_dir,
                    o_cabin_floor, o_goal_floor, o_is_busy};
            results++;
            if (got.dv)
                dispatches++;
            if (predicted_status_q.size() == 0) begin
                $error("result strobe with no transfer outstanding");
                errors++;
            end else begin
                want = predicted_status_q.pop_front();
                check_field("dispatch_valid", want.dv, got.dv);
                check_field("dispatch_floor", want.df, got.df);
                check_field("dispatch_dir", int'($signed(want.dd)), int'($signed(got.dd)));
                check_field("cabin_floor", want.cf, got.cf);
                check_field("goal_floor", want.gf, got.gf);
                check_field("is_busy", want.ib, got.ib);
            end
        end
        if (took) begin
            ev.mode = i_mode;
            ev.floor = i_floor;
            ev.mdir = i_move_dir;
            predicted_status_q.push_back(schedule_event(ev));
            mode_seen[ev.mode]++;
            transfers++;
        end
    end

    initial begin
        int counted;
        int n;
        int k;
        int f;
        int last_req;
        logic [1:0] heading;

        // directed: ends of the shaft, ignored events, goal handling
        add_event(MODE_MOVE, 5'd1, DIR_UP);
        add_event(MODE_ARRIVE, 5'd1, DIR_STAY);
        add_event(MODE_REQUEST, 5'd16, DIR_STAY);
        add_event(MODE_REQUEST, 5'd1, DIR_UP);
        add_event(MODE_MOVE, 5'd0, DIR_UP);
        add_event(MODE_MOVE, 5'd31, 2'b10);
        add_event(MODE_MOVE, 5'd2, DIR_DOWN);
        add_event(MODE_MOVE, 5'd2, DIR_DOWN);
        add_event(MODE_ARRIVE, 5'd16, DIR_STAY);
        add_event(MODE_MOVE, 5'd16, DIR_UP);
        add_event(MODE_REQUEST, 5'd0, DIR_STAY);
        add_event(MODE_REQUEST, 5'd17, DIR_UP);
        add_event(MODE_REQUEST, 5'd31, DIR_DOWN);
        add_event(MODE_ARRIVE, 5'd0, DIR_STAY);
        add_event(MODE_ARRIVE, 5'd31, DIR_STAY);
        add_event(2'd3, 5'd31, 2'b10);
        add_event(MODE_REQUEST, 5'd1, DIR_STAY);
        add_event(MODE_ARRIVE, 5'd1, DIR_STAY);
        add_event(MODE_REQUEST, 5'd8, DIR_STAY);
        add_event(MODE_REQUEST, 5'd8, DIR_STAY);
        add_event(MODE_REQUEST, 5'd3, DIR_STAY);
        add_event(MODE_REQUEST, 5'd12, DIR_STAY);
        add_event(MODE_ARRIVE, 5'd5, DIR_STAY);
        add_event(MODE_ARRIVE, 5'd12, DIR_STAY);
        add_event(MODE_ARRIVE, 5'd3, DIR_STAY);
        add_event(MODE_REQUEST, 5'd3, DIR_STAY);

        // random trips: requests, a run of moves, then an arrival; some noise
        counted = 0;
        last_req = 1;
        while (counted < RANDOM_EVENTS) begin
            if ($urandom_range(9) == 0) begin
                add_event(2'($urandom_range(3)), 5'($urandom_range(31)),
                          2'($urandom_range(3)));
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    last_req = $urandom_range(1, FLOORS);
                    add_event(MODE_REQUEST, 5'(last_req), 2'($urandom_range(3)));
                end
                k = $urandom_range(0, 6);
                heading = $urandom_range(1) ? DIR_UP : DIR_DOWN;
                repeat (k)
                    add_event(MODE_MOVE, 5'($urandom_range(31)),
                              ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : heading);
                case ($urandom_range(3))
                    0: f = $urandom_range(1, FLOORS);
                    3: f = $urandom_range(1) ? 1 : FLOORS;
                    default: f = last_req;
                endcase
                add_event(MODE_ARRIVE, 5'(f), 2'($urandom_range(3)));
                counted += n + k + 1;
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (panel_events_q.size() != 0)
            @(posedge i_clk);
        while (predicted_status_q.size() != 0)
            @(posedge i_clk);
        repeat (2 * FLOORS + 8) @(posedge i_clk);

        $display("covered %0d transfers: %0d requests, %0d arrivals, %0d moves, %0d unused mode",
                 transfers, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
        $display("checked %0d results, %0d of them dispatches, %0d mismatches",
                 results, dispatches, errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
